>>> hdl/sfh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point vector length block.
// No dependencies; imported by every module under hdl.
package sfh_pkg;

  localparam int FRAC_BITS = 16;                // fraction bits of the 16.16 format
  localparam int DEF_MAX_ROUNDS = 16;           // default reflection round limit
  localparam logic [31:0] MAG_LIMIT = 32'h2fff_ffff;
  localparam logic [31:0] FOUR_FIX = 32'h0004_0000;
  localparam logic [31:0] DIV_ZERO_QUOT = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } sfh_in_t;

  typedef struct packed {
    logic [30:0] distance;
    logic        overflow;
  } sfh_out_t;

  // Request to the shared divider: quotient = (dividend << 16) / divisor.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } sfh_div_req_t;

endpackage

>>> hdl/safe_fixed_point_hypot.sv
`timescale 1ns / 1ps
// Vector length sqrt(x*x + y*y) of two signed 16.16 values, without forming squares.
// Depends on sfh_pkg, sfh_div and sfh_mul.
//
// Pulse start while busy is low to transfer one operand pair; the block raises
// busy and runs a reflection iteration on the magnitudes (larger a, smaller b):
// r = (b/a)^2, r = r/(r+4), a += 2*a*r, b *= r, until r reaches zero or
// MAX_ROUNDS rounds are done. One divider (one quotient bit per cycle) and one
// 32x32 multiplier (registered product) are shared by all steps. A converging
// final round only finds the squared ratio zero; most inputs need only a few
// rounds. Overflow and zero inputs give their result from the check state,
// without entering the loop. Busy drops in the cycle of the result. The
// result shows for exactly one cycle with result_valid high and must be
// captured then: the receiver cannot stall it. A larger magnitude above
// 0x2fffffff, including the most negative input, gives distance 0, overflow 1.
module safe_fixed_point_hypot #(
  parameter int MAX_ROUNDS = sfh_pkg::DEF_MAX_ROUNDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sfh_pkg::sfh_in_t  operands,
  output logic              result_valid,
  output sfh_pkg::sfh_out_t result
);
  import sfh_pkg::*;

  localparam int RW = $clog2(MAX_ROUNDS + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ORDER  = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_D1GO   = 4'd3;
  localparam logic [3:0] S_D1WAIT = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_TEST   = 4'd6;
  localparam logic [3:0] S_D2GO   = 4'd7;
  localparam logic [3:0] S_D2WAIT = 4'd8;
  localparam logic [3:0] S_GROW   = 4'd9;
  localparam logic [3:0] S_SHRINK = 4'd10;
  localparam logic [3:0] S_UPD    = 4'd11;

  logic [3:0]    state;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   t;
  logic [RW-1:0] round;
  logic [RW-1:0] round_next;

  sfh_div_req_t  div_req;
  logic          div_done;
  logic [31:0]   div_quot;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [31:0]   mul_prod;
  logic [31:0]   x_mag;
  logic [31:0]   y_mag;

  // Two's complement magnitude; the most negative value stays 0x80000000
  // and is caught by the limit check.
  assign x_mag = operands.x_value[31] ? 32'(-operands.x_value) : operands.x_value;
  assign y_mag = operands.y_value[31] ? 32'(-operands.y_value) : operands.y_value;

  assign busy       = (state != S_IDLE);
  assign round_next = round + RW'(1);

  // Issue divisions: b/a to form the ratio, then r/(r+4).
  always_comb begin
    div_req = '0;
    if (state == S_D1GO) begin
      div_req.start    = 1'b1;
      div_req.dividend = b;
      div_req.divisor  = a;
    end else if (state == S_D2GO) begin
      div_req.start    = 1'b1;
      div_req.dividend = t;
      div_req.divisor  = t + FOUR_FIX;
    end
  end

  // Steer the shared multiplier; its product is ready in the next cycle.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = t;
        mul_b = t;
      end
      S_GROW: begin
        mul_a = {a[30:0], 1'b0};
        mul_b = t;
      end
      S_SHRINK: begin
        mul_a = b;
        mul_b = t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  sfh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  sfh_mul u_mul (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      round        <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            a     <= x_mag;
            b     <= y_mag;
            state <= S_ORDER;
          end
        end
        S_ORDER: begin
          // Keep the larger magnitude in a.
          if (a < b) begin
            a <= b;
            b <= a;
          end
          state <= S_CHECK;
        end
        S_CHECK: begin
          round <= '0;
          if (a > MAG_LIMIT) begin
            result.distance <= '0;
            result.overflow <= 1'b1;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else if (a == '0) begin
            result.distance <= '0;
            result.overflow <= 1'b0;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_D1GO;
          end
        end
        S_D1GO: begin
          state <= S_D1WAIT;
        end
        S_D1WAIT: begin
          if (div_done) begin
            t     <= div_quot;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          state <= S_TEST;
        end
        S_TEST: begin
          // Converged once the squared ratio vanishes.
          if (mul_prod == '0) begin
            result.distance <= a[30:0];
            result.overflow <= 1'b0;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else begin
            t     <= mul_prod;
            state <= S_D2GO;
          end
        end
        S_D2GO: begin
          state <= S_D2WAIT;
        end
        S_D2WAIT: begin
          if (div_done) begin
            t     <= div_quot;
            state <= S_GROW;
          end
        end
        S_GROW: begin
          state <= S_SHRINK;
        end
        S_SHRINK: begin
          a     <= a + mul_prod;
          state <= S_UPD;
        end
        S_UPD: begin
          b     <= mul_prod;
          round <= round_next;
          if (round_next == RW'(MAX_ROUNDS)) begin
            result.distance <= a[30:0];
            result.overflow <= 1'b0;
            result_valid    <= 1'b1;
            state           <= S_IDLE;
          end else begin
            state <= S_D1GO;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/sfh_div.sv
`timescale 1ns / 1ps
// Shared fixed-point divider, one quotient bit per cycle.
// Depends on sfh_pkg for the request type and format constants.
module sfh_div (
  input  logic                 clk,
  input  logic                 rst,
  input  sfh_pkg::sfh_div_req_t req,
  output logic                 done,
  output logic [31:0]          quotient
);
  import sfh_pkg::*;

  localparam int CW = $clog2(FRAC_BITS + 1);

  logic [31:0]   divisor;
  logic [31:0]   rem;
  logic [FRAC_BITS:0] quot;
  logic [CW-1:0] cnt;
  logic          by_zero;
  logic [32:0]   shifted;
  logic [32:0]   diff;
  logic          ge;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, divisor};
  assign ge      = shifted >= {1'b0, divisor};

  // Callers guarantee dividend <= divisor, so the integer part is one bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt     <= CW'(FRAC_BITS);
        divisor <= req.divisor;
        by_zero <= (req.divisor == '0);
        if (req.dividend >= req.divisor) begin
          rem  <= req.dividend - req.divisor;
          quot <= (FRAC_BITS + 1)'(1);
        end else begin
          rem  <= req.dividend;
          quot <= '0;
        end
      end else if (cnt != '0) begin
        rem  <= ge ? diff[31:0] : shifted[31:0];
        quot <= {quot[FRAC_BITS-1:0], ge};
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = by_zero ? DIV_ZERO_QUOT : {{(32 - FRAC_BITS - 1){1'b0}}, quot};

endmodule

>>> hdl/sfh_mul.sv
`timescale 1ns / 1ps
// Shared fixed-point multiplier with a registered product.
// Depends on sfh_pkg for the fraction width.
module sfh_mul (
  input  logic        clk,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic [31:0] product
);
  import sfh_pkg::*;

  logic [63:0] prod_full;

  always_ff @(posedge clk) begin
    prod_full <= 64'(op_a) * 64'(op_b);
  end

  // Drop the fraction bits and keep 32 bits of the 16.16 result.
  assign product = prod_full[FRAC_BITS +: 32];

endmodule

>>> dv/tb_safe_fixed_point_hypot.sv
`timescale 1ns / 1ps
// Self-checking bench for safe_fixed_point_hypot: a random-gap driver and a result checker.
// Depends on sfh_pkg and the safe_fixed_point_hypot RTL; needs nothing else.
module tb_safe_fixed_point_hypot;
  import sfh_pkg::*;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  sfh_in_t  operands = '0;
  logic     result_valid;
  sfh_out_t result;

  sfh_in_t  pending_pairs[$];   // operand pairs not yet handed to the block
  sfh_out_t lengths_due[$];     // predicted results, oldest first
  int       pairs_total = 0;
  int       pairs_taken = 0;
  int       mismatches = 0;
  int       idle_left = 0;
  int       gap;
  logic     took = 1'b0;        // a transfer happened at the last rising edge

  safe_fixed_point_hypot dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operands     (operands),
    .result_valid (result_valid),
    .result       (result)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction: 16.16 fixed multiply and divide as the block does them, then the
  // reflection loop on the ordered magnitudes.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] fix_mul(logic [31:0] p, logic [31:0] q);
    logic [63:0] prod;
    prod = {32'd0, p} * {32'd0, q};
    return prod[47:16];
  endfunction

  function automatic logic [31:0] fix_div(logic [31:0] p, logic [31:0] q);
    logic [63:0] quot;
    if (q == 32'd0) return DIV_ZERO_QUOT;
    quot = {16'd0, p, 16'd0} / {32'd0, q};
    return quot[31:0];
  endfunction

  function automatic sfh_out_t vector_length(sfh_in_t op);
    logic [31:0] big, tiny, ratio, swap;
    sfh_out_t    res;
    // Magnitudes wrap like two's complement: the most negative value stays
    // 0x80000000, which lands above the limit.
    big  = op.x_value[31] ? ~op.x_value + 32'd1 : op.x_value;
    tiny = op.y_value[31] ? ~op.y_value + 32'd1 : op.y_value;
    if (big < tiny) begin
      swap = big;
      big  = tiny;
      tiny = swap;
    end
    res = '0;
    if (big > MAG_LIMIT) begin
      res.overflow = 1'b1;
      return res;
    end
    if (big != 32'd0) begin
      for (int n = 0; n < DEF_MAX_ROUNDS; n++) begin
        ratio = fix_div(tiny, big);
        ratio = fix_mul(ratio, ratio);
        if (ratio == 32'd0) break;
        ratio = fix_div(ratio, ratio + FOUR_FIX);
        big   = big + fix_mul(big << 1, ratio);
        tiny  = fix_mul(tiny, ratio);
      end
    end
    res.distance = big[30:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] signed_mag(logic [31:0] mag);
    return $urandom_range(0, 1) ? ~mag + 32'd1 : mag;
  endfunction

  // Pick one coordinate from a mix weighted toward the in-range interior.
  function automatic logic [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return signed_mag($urandom_range(0, MAG_LIMIT));
    if (r < 72) return signed_mag($urandom_range(0, 32'h0004_0000));
    if (r < 78) return 32'd0;
    if (r < 86) return signed_mag(MAG_LIMIT - 32'd64 + $urandom_range(0, 128));
    if (r < 87) return 32'h8000_0000;
    return $urandom;
  endfunction

  // Most gaps are short, some zero-length runs, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic add_pair(logic [31:0] xv, logic [31:0] yv);
    sfh_in_t op;
    op.x_value = xv;
    op.y_value = yv;
    pending_pairs.push_back(op);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only. Keep start high across
  // back-to-back transfers with a single assignment per step.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else if (start && took) begin
      // the current pair was just transferred; advance or go idle
      gap = pick_gap();
      if (gap == 0 && pending_pairs.size() != 0) begin
        operands <= pending_pairs.pop_front();
      end else begin
        start     <= 1'b0;
        idle_left <= gap;
        operands  <= {$urandom, $urandom};
      end
    end else if (!start) begin
      if (idle_left != 0) begin
        // scramble the idle operand bus: the block must ignore it
        idle_left <= idle_left - 1;
        operands  <= {$urandom, $urandom};
      end else if (pending_pairs.size() != 0) begin
        operands <= pending_pairs.pop_front();
        start    <= 1'b1;
      end
    end
    // start high while busy: hold the pair until it is taken
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge. Check the result strobe against the
  // oldest prediction, then record any new transfer and predict its length.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      took <= 1'b0;
    end else begin
      if (result_valid) begin
        if (lengths_due.size() == 0) begin
          $error("unexpected result: distance %h overflow %b", result.distance,
                 result.overflow);
          mismatches++;
        end else begin
          sfh_out_t want;
          want = lengths_due.pop_front();
          if (result.distance !== want.distance) begin
            $error("distance: expected %h, actual %h", want.distance, result.distance);
            mismatches++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %b, actual %b", want.overflow, result.overflow);
            mismatches++;
          end
        end
      end
      took <= start && !busy;
      if (start && !busy) begin
        lengths_due.push_back(vector_length(operands));
        pairs_taken++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: fill the pair queue, release reset, wait for the last result.
  // ---------------------------------------------------------------------------
  initial begin
    // zero, unit and limit corners
    add_pair(32'd0, 32'd0);
    add_pair(32'd1, 32'd0);
    add_pair(32'd0, 32'hffff_ffff);
    add_pair(32'd1, 32'd1);
    add_pair(32'hffff_ffff, 32'hffff_ffff);
    add_pair(MAG_LIMIT, 32'd0);
    add_pair(32'd0, ~MAG_LIMIT + 32'd1);
    add_pair(MAG_LIMIT, MAG_LIMIT);
    add_pair(~MAG_LIMIT + 32'd1, MAG_LIMIT);
    add_pair(32'd1, MAG_LIMIT);
    // just above the limit on either coordinate
    add_pair(MAG_LIMIT + 32'd1, 32'd0);
    add_pair(32'd0, MAG_LIMIT + 32'd1);
    add_pair(~(MAG_LIMIT + 32'd1) + 32'd1, 32'd5);
    // most negative input: the magnitude wraps and must flag overflow; then the largest positive values
    add_pair(32'h8000_0000, 32'd0);
    add_pair(32'd0, 32'h8000_0000);
    add_pair(32'h8000_0000, 32'h8000_0000);
    add_pair(32'h7fff_ffff, 32'h7fff_ffff);
    add_pair(32'h7fff_ffff, 32'hffff_ffff);
    // ordinary vectors, including exact Pythagorean triples
    add_pair(32'h0001_0000, 32'h0001_0000);
    add_pair(32'h0003_0000, 32'h0004_0000);
    add_pair(32'hfffb_0000, 32'h000c_0000);
    add_pair(32'h1234_5678, 32'hf123_4568);
    add_pair(32'h0000_0001, 32'h2000_0000);
    for (int i = 0; i < 1400; i++) add_pair(pick_coord(), pick_coord());
    pairs_total = pending_pairs.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pairs_taken < pairs_total) @(posedge clk);
    while (lengths_due.size() != 0) @(posedge clk);
    // let a full worst-case item pass to catch any stray result
    repeat (800) @(posedge clk);

    if (mismatches == 0 && lengths_due.size() == 0) begin
      $display("safe_fixed_point_hypot regression: pass");
    end else begin
      $display("safe_fixed_point_hypot regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("safe_fixed_point_hypot regression: fail");
    $finish;
  end

endmodule

>>> safe_fixed_point_hypot.f
hdl/sfh_pkg.sv
hdl/sfh_div.sv
hdl/sfh_mul.sv
hdl/safe_fixed_point_hypot.sv
dv/tb_safe_fixed_point_hypot.sv
